[hw/rtl/bpg_pkg.sv]
// Shared constants, threshold table and lookup function for the battery percent gauge.
// Used by bpg_window and battery_percent_gauge_top; depends on nothing else.
package bpg_pkg;

    localparam int SAMPLE_W            = 12;
    localparam int PERCENT_W           = 7;
    localparam int DEFAULT_WINDOW_SIZE = 8;

    // Pack voltage in millivolts is floor(avg * 103 / 3); all comparisons are made on
    // avg * 103 against three times the millivolt limit, so no division by three is needed.
    localparam int PACK_W   = 19;
    localparam int PACK_MUL = 103;

    // Strict band edges: q > T holds exactly when avg * 103 >= 3 * T + 3.
    localparam logic [PACK_W-1:0] BAND_HIGH_X3 = PACK_W'(3 * 55000 + 3);
    localparam logic [PACK_W-1:0] BAND_MID_X3  = PACK_W'(3 * 40000 + 3);
    localparam logic [PACK_W-1:0] BAND_LOW_X3  = PACK_W'(3 * 28000 + 3);

    // Reciprocal multipliers for floor(x / 5) and floor(x / 3) on 14-bit operands.
    localparam int SCALED_W   = SAMPLE_W + 2;
    localparam int RECIP_W    = 15;
    localparam int DIV5_SHIFT = 17;
    localparam int DIV3_SHIFT = 16;
    localparam logic [RECIP_W-1:0] DIV5_MUL = RECIP_W'(((1 << DIV5_SHIFT) + 4) / 5);
    localparam logic [RECIP_W-1:0] DIV3_MUL = RECIP_W'(((1 << DIV3_SHIFT) + 2) / 3);

    localparam int LEVEL_COUNT = 100;
    localparam int LEVEL_IDX_W = $clog2(LEVEL_COUNT);

    typedef logic [PACK_W-1:0] t_level;

    // Entry p-1 is three times the smallest pack millivolt value that gives at least p percent.
    localparam int LEVEL_X3 [LEVEL_COUNT] = '{
        3*37873, 3*39809, 3*40942, 3*41745, 3*42368, 3*42877, 3*43308, 3*43681, 3*44010,
        3*44304, 3*44570, 3*44813, 3*45037, 3*45244, 3*45436, 3*45617, 3*45786, 3*45945,
        3*46096, 3*46240, 3*46376, 3*46506, 3*46630, 3*46749, 3*46863, 3*46972, 3*47078,
        3*47179, 3*47277, 3*47372, 3*47464, 3*47552, 3*47638, 3*47722, 3*47803, 3*47881,
        3*47958, 3*48032, 3*48105, 3*48175, 3*48244, 3*48312, 3*48377, 3*48442, 3*48504,
        3*48566, 3*48626, 3*48685, 3*48742, 3*48799, 3*48854, 3*48908, 3*48961, 3*49014,
        3*49065, 3*49115, 3*49165, 3*49213, 3*49261, 3*49308, 3*49354, 3*49399, 3*49444,
        3*49488, 3*49531, 3*49574, 3*49616, 3*49657, 3*49698, 3*49738, 3*49778, 3*49817,
        3*49855, 3*49893, 3*49931, 3*49968, 3*50004, 3*50040, 3*50076, 3*50111, 3*50146,
        3*50180, 3*50214, 3*50247, 3*50280, 3*50313, 3*50345, 3*50377, 3*50409, 3*50440,
        3*50471, 3*50501, 3*50532, 3*50562, 3*50591, 3*50620, 3*50649, 3*50678, 3*50706,
        3*50734
    };

    // Counts the thresholds that the scaled pack value reaches by a binary search over
    // the monotonic table; the count saturates at one hundred by construction.
    function automatic logic [PERCENT_W-1:0] level_count(input logic [PACK_W-1:0] pack_x3);
        logic [PERCENT_W-1:0] p;
        logic [PERCENT_W:0]   cand;
        p = '0;
        for (int b = PERCENT_W - 1; b >= 0; b--) begin
            cand = {1'b0, p} + ((PERCENT_W + 1)'(1) << b);
            if (cand <= (PERCENT_W + 1)'(LEVEL_COUNT) &&
                pack_x3 >= t_level'(LEVEL_X3[cand[LEVEL_IDX_W-1:0] - LEVEL_IDX_W'(1)])) begin
                p = cand[PERCENT_W-1:0];
            end
        end
        return p;
    endfunction

endpackage

[hw/rtl/battery_percent_gauge_top.sv]
// Top level of the battery percent gauge: handshake, averaging, band scaling and lookup.
// Depends on bpg_pkg and bpg_window.
//
// Each transfer on the input channel carries one divider sample in millivolts and yields
// exactly one charge percent (0 to 100) on the output channel, worked out from the average
// of the last WINDOW_SIZE samples including this one; the window holds zeros after reset.
// The block takes one sample in every cycle while held results do not stall it; each result
// passes the running sum update, then the averaging multiply, the band scaling,
// the pack voltage multiply and the threshold search, each registered.
// Held results do not stop the input until all five stages are full.
module battery_percent_gauge_top
    import bpg_pkg::*;
#(
    parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SAMPLE_W-1:0]  i_sample_mv,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PERCENT_W-1:0] o_percent
);

    localparam int    LOG_W     = $clog2(WINDOW_SIZE);
    localparam int    SUM_W     = SAMPLE_W + LOG_W;
    localparam int    DIV_SHIFT = SUM_W + LOG_W;
    localparam int    MUL_W     = SUM_W + 1;
    localparam int    PROD_W    = SUM_W + MUL_W;
    localparam longint AVG_MUL_L =
        ((longint'(1) << DIV_SHIFT) + longint'(WINDOW_SIZE) - 1) / longint'(WINDOW_SIZE);
    localparam logic [MUL_W-1:0] AVG_MUL = MUL_W'(AVG_MUL_L);

    logic                 ld_sum;
    logic                 ld_avg;
    logic                 ld_norm;
    logic                 ld_vq;
    logic                 ld_out;
    logic                 accept;

    logic                 r_sum_valid;
    logic                 r_avg_valid;
    logic                 r_norm_valid;
    logic                 r_vq_valid;
    logic                 r_out_valid;

    logic [SUM_W-1:0]     win_sum;
    logic [PROD_W-1:0]    avg_prod;
    logic [SAMPLE_W-1:0]  r_avg;

    logic [PACK_W-1:0]    avg_x103;
    logic [SCALED_W-1:0]  avg_x4;
    logic [SCALED_W+RECIP_W-1:0] prod5;
    logic [SCALED_W+RECIP_W-1:0] prod3;
    logic [SAMPLE_W-1:0]  n_norm;
    logic [SAMPLE_W-1:0]  r_norm;

    logic [PACK_W-1:0]    r_vq;
    logic [PERCENT_W-1:0] r_percent;

    assign ld_out     = !r_out_valid || i_out_ready;
    assign ld_vq      = !r_vq_valid || ld_out;
    assign ld_norm    = !r_norm_valid || ld_vq;
    assign ld_avg     = !r_avg_valid || ld_norm;
    assign ld_sum     = !r_sum_valid || ld_avg;
    assign o_in_ready = ld_sum;
    assign accept     = i_in_valid && ld_sum;

    bpg_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_sample_mv (i_sample_mv),
        .o_sum       (win_sum)
    );

    // Floor division of the sum by the window size through an exact reciprocal.
    assign avg_prod = PROD_W'(win_sum) * PROD_W'(AVG_MUL);

    // Band selection and rescaling to the 48 V reference.
    assign avg_x103 = PACK_W'(r_avg) * PACK_W'(PACK_MUL);
    assign avg_x4   = {r_avg, 2'b00};
    assign prod5    = (SCALED_W + RECIP_W)'(avg_x4) * (SCALED_W + RECIP_W)'(DIV5_MUL);
    assign prod3    = (SCALED_W + RECIP_W)'(avg_x4) * (SCALED_W + RECIP_W)'(DIV3_MUL);

    always_comb begin
        priority if (avg_x103 >= BAND_HIGH_X3) begin
            n_norm = prod5[DIV5_SHIFT +: SAMPLE_W];
        end else if (avg_x103 >= BAND_MID_X3) begin
            n_norm = r_avg;
        end else if (avg_x103 >= BAND_LOW_X3) begin
            n_norm = prod3[DIV3_SHIFT +: SAMPLE_W];
        end else begin
            n_norm = r_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid  <= 1'b0;
            r_avg_valid  <= 1'b0;
            r_norm_valid <= 1'b0;
            r_vq_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (ld_sum) begin
                r_sum_valid <= accept;
            end
            if (ld_avg) begin
                r_avg_valid <= r_sum_valid;
            end
            if (ld_norm) begin
                r_norm_valid <= r_avg_valid;
            end
            if (ld_vq) begin
                r_vq_valid <= r_norm_valid;
            end
            if (ld_out) begin
                r_out_valid <= r_vq_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_avg && r_sum_valid) begin
            r_avg <= avg_prod[DIV_SHIFT +: SAMPLE_W];
        end
        if (ld_norm && r_avg_valid) begin
            r_norm <= n_norm;
        end
        if (ld_vq && r_norm_valid) begin
            r_vq <= PACK_W'(r_norm) * PACK_W'(PACK_MUL);
        end
        if (ld_out && r_vq_valid) begin
            r_percent <= level_count(r_vq);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_percent   = r_percent;

`ifndef SYNTHESIS
    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_percent <= PERCENT_W'(LEVEL_COUNT))
        else $error("Percent result above one hundred.");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_valid && r_avg_valid && r_norm_valid && r_vq_valid && r_out_valid &&
         !i_out_ready) |-> !o_in_ready)
        else $error("Input accepted while every stage is held.");

    a_low_pack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && r_vq_valid && r_vq < t_level'(LEVEL_X3[0])) |=>
        (o_out_valid && o_percent == '0))
        else $error("Pack voltage below the curve gave a nonzero percent.");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vq_valid && ld_out) |=> o_out_valid)
        else $error("Result lost between the last two stages.");
`endif

endmodule

[hw/rtl/bpg_window.sv]
// Sample window of the battery percent gauge: a shift line of samples and its running sum.
// Depends on bpg_pkg.
module bpg_window
    import bpg_pkg::*;
#(
    parameter int  WINDOW_SIZE = DEFAULT_WINDOW_SIZE,
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_SIZE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [SAMPLE_W-1:0] i_sample_mv,
    output logic [SUM_W-1:0]    o_sum
);

    logic [SAMPLE_W-1:0] r_taps [WINDOW_SIZE];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    // The oldest sample leaves from the last tap as the new one enters the first.
    assign n_sum = r_sum - SUM_W'(r_taps[WINDOW_SIZE-1]) + SUM_W'(i_sample_mv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_taps[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_load) begin
            r_taps[0] <= i_sample_mv;
            for (int i = 1; i < WINDOW_SIZE; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for battery_percent_gauge_top: a queue-fed driver offers millivolt
// samples, a monitor checks every charge percent against an in-bench window average model.
// Depends on bpg_pkg and the gauge RTL.
module tb_top;
    import bpg_pkg::*;

    localparam int GAUGE_DEPTH = 8;
    localparam int N_STEPS     = 100;
    localparam int HOLD_CYCLES = 80;

    // Smallest normalised pack voltage in millivolts giving at least p percent, at index p-1.
    localparam int unsigned STEP_MV [N_STEPS] = '{
        37873, 39809, 40942, 41745, 42368, 42877, 43308, 43681, 44010, 44304,
        44570, 44813, 45037, 45244, 45436, 45617, 45786, 45945, 46096, 46240,
        46376, 46506, 46630, 46749, 46863, 46972, 47078, 47179, 47277, 47372,
        47464, 47552, 47638, 47722, 47803, 47881, 47958, 48032, 48105, 48175,
        48244, 48312, 48377, 48442, 48504, 48566, 48626, 48685, 48742, 48799,
        48854, 48908, 48961, 49014, 49065, 49115, 49165, 49213, 49261, 49308,
        49354, 49399, 49444, 49488, 49531, 49574, 49616, 49657, 49698, 49738,
        49778, 49817, 49855, 49893, 49931, 49968, 50004, 50040, 50076, 50111,
        50146, 50180, 50214, 50247, 50280, 50313, 50345, 50377, 50409, 50440,
        50471, 50501, 50532, 50562, 50591, 50620, 50649, 50678, 50706, 50734
    };

    // Averages that sit on either side of the three band limits.
    localparam int BAND_AVG [6] = '{1601, 1602, 1165, 1166, 815, 816};

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [SAMPLE_W-1:0]  i_sample_mv = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [PERCENT_W-1:0] o_percent;

    battery_percent_gauge_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_mv (i_sample_mv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_percent   (o_percent)
    );

    logic [SAMPLE_W-1:0]  sample_backlog [$];
    logic [PERCENT_W-1:0] percent_due [$];

    logic [SAMPLE_W-1:0] gauge_window [GAUGE_DEPTH];
    logic [2:0]          gauge_slot;
    logic [14:0]         gauge_sum;

    int n_sent       = 0;
    int n_seen       = 0;
    int mismatch_cnt = 0;
    int hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_cnt++;
    endtask

    // Advances the averaging window by one sample and returns the charge percent.
    function automatic logic [PERCENT_W-1:0] predict_percent(input logic [SAMPLE_W-1:0] mv);
        logic [SAMPLE_W-1:0]  avg;
        int unsigned          pack_mv;
        int unsigned          norm;
        int unsigned          norm_mv;
        logic [PERCENT_W-1:0] pct;
        gauge_sum = gauge_sum - 15'(gauge_window[gauge_slot]) + 15'(mv);
        gauge_window[gauge_slot] = mv;
        gauge_slot = gauge_slot + 3'd1;
        avg = gauge_sum[14:3];
        pack_mv = (int'(avg) * 103) / 3;
        if (pack_mv > 55000)
            norm = (int'(avg) * 48) / 60;
        else if (pack_mv > 40000)
            norm = 32'(avg);
        else if (pack_mv > 28000)
            norm = (int'(avg) * 48) / 36;
        else
            norm = 32'(avg);
        norm_mv = (norm * 103) / 3;
        pct = '0;
        for (int i = 0; i < N_STEPS; i++) begin
            if (norm_mv >= STEP_MV[i])
                pct = PERCENT_W'(i + 1);
        end
        return pct;
    endfunction

    // Mostly runs of a full window near the band limits or across the charge curve,
    // with runs of one to eight random samples in between.
    task automatic queue_batch(input int n_items);
        int added;
        int kind;
        int base;
        int len;
        int mv;
        added = 0;
        while (added < n_items) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                base = BAND_AVG[$urandom_range(5)];
                for (int i = 0; i < GAUGE_DEPTH; i++) begin
                    mv = ($urandom_range(1) == 0) ? base : base + $urandom_range(2) - 1;
                    sample_backlog.push_back(SAMPLE_W'(mv));
                end
                added += GAUGE_DEPTH;
            end else if (kind < 70) begin
                base = $urandom_range(1700, 1100);
                for (int i = 0; i < GAUGE_DEPTH; i++) begin
                    mv = base + $urandom_range(80) - 40;
                    sample_backlog.push_back(SAMPLE_W'(mv));
                end
                added += GAUGE_DEPTH;
            end else begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    sample_backlog.push_back(SAMPLE_W'($urandom_range(4095)));
                added += len;
            end
        end
    endtask

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || i_in_valid || percent_due.size() != 0)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_in
        bit slot_free;
        bit quiet;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_sample_mv <= '0;
            for (int i = 0; i < GAUGE_DEPTH; i++)
                gauge_window[i] = '0;
            gauge_slot = '0;
            gauge_sum  = '0;
        end else begin
            slot_free = !i_in_valid || o_in_ready;
            if (i_in_valid && o_in_ready) begin
                percent_due.push_back(predict_percent(i_sample_mv));
                n_sent++;
            end
            quiet = (n_sent >= 500 && n_sent < 700);
            if (slot_free) begin
                if (sample_backlog.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
                    i_sample_mv <= sample_backlog.pop_front();
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        logic [PERCENT_W-1:0] want;
        bit quiet;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (percent_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, percent %0d", o_percent));
                end else begin
                    want = percent_due.pop_front();
                    if (o_percent !== want)
                        flag_mismatch($sformatf("result %0d: percent %0d, expected %0d",
                                                n_seen, o_percent, want));
                end
                n_seen++;
                // A long back-pressure stretch lets the pipeline fill and stall the input.
                if (n_seen == 300 || n_seen == 900)
                    hold_left = HOLD_CYCLES;
            end
            quiet = (n_seen >= 500 && n_seen < 700);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= 14);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty window, full scale, then full windows just above the upper two band limits.
        sample_backlog.push_back(SAMPLE_W'(0));
        for (int i = 0; i < GAUGE_DEPTH; i++)
            sample_backlog.push_back(SAMPLE_W'(4095));
        for (int i = 0; i < GAUGE_DEPTH; i++)
            sample_backlog.push_back(SAMPLE_W'(1602));
        for (int i = 0; i < GAUGE_DEPTH; i++)
            sample_backlog.push_back(SAMPLE_W'(1166));
        wait_drained();

        for (int b = 0; b < 5; b++) begin
            queue_batch(245);
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (percent_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", percent_due.size()));
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bpg_pkg.sv
hw/rtl/bpg_window.sv
hw/rtl/battery_percent_gauge_top.sv
dv/tb_top.sv
